// File: src/lspe_pkg.sv
// lspe_pkg: payload types, command and register codes, and the gamma table
// for the LED strip pulse encoder. No dependencies.
`default_nettype none

package lspe_pkg;

   localparam int unsigned LED_BITS        = 24;
   localparam int unsigned TRAIL_ZERO_BITS = 23;
   localparam int unsigned BRIGHT_MAX      = 100;
   // x / 100 for x <= 25500 as (x * 5243) >> 19
   localparam int unsigned DIV100_MUL      = 5243;
   localparam int unsigned DIV100_SHIFT    = 19;

   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_READ    = 3'd2;
   localparam logic [2:0] FUNC_SET_ALL = 3'd3;
   localparam logic [2:0] FUNC_ALL_OFF = 3'd4;

   localparam logic [1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [1:0] CSR_BIT_PERIOD = 2'd1;
   localparam logic [1:0] CSR_ZERO_HIGH  = 2'd2;
   localparam logic [1:0] CSR_ONE_HIGH   = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  led_index;
      logic [23:0] new_color;
   } req_type;

   typedef struct packed {
      logic        line_level;
      logic [23:0] read_color;
      logic        frame_start;
   } rsp_type;

   typedef logic [255:0][7:0] gamma_rom_type;

   // exact test: (2v-1)^9 * 255^11 <= i^20 * 2^9
   function automatic logic rounds_up_to(int unsigned i, int unsigned v);
      logic [191:0] a;
      logic [191:0] b;
      a = 192'd1;
      b = 192'd512;
      for (int k = 0; k < 9; k++) a = a * 192'(2 * v - 1);
      for (int k = 0; k < 11; k++) a = a * 192'd255;
      for (int k = 0; k < 20; k++) b = b * 192'(i);
      return a <= b;
   endfunction

   function automatic gamma_rom_type build_gamma();
      gamma_rom_type t;
      int unsigned   v;
      v = 0;
      for (int i = 0; i < 256; i++) begin
         while (v < 255 && rounds_up_to(i, v + 1)) v++;
         t[i] = 8'(v);
      end
      return t;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

// File: src/led_strip_pulse_encoder.sv
// led_strip_pulse_encoder: colour store and one-wire pulse-width line encoder.
// Depends on lspe_pkg (payload types, codes, gamma table).
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_data (func, led_index, new_color)
//   rsp       out        rsp_valid/rsp_ready    rsp_data (line_level, read_color, frame_start)
//   csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One item at a time: accept, then an execute step; no new item is taken until it ends.
// A tick that starts a data bit reads the store at accept and then passes through
// S_MUL (brightness multiply), S_DIV (reciprocal divide by 100) and S_GAM (gamma lookup).
// Reset clears the store at once through per-LED valid bits and a fill colour;
// set all and all off work the same way in the execute step.
// A result waiting on rsp_ready holds the execute step; csr is always ready.
`default_nettype none

module led_strip_pulse_encoder
   import lspe_pkg::*;
#(
   parameter int unsigned LED_COUNT = 64,
   parameter int unsigned PAD_BITS  = 50
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int unsigned PTR_W     = $clog2(LED_COUNT + 1);
   localparam int unsigned TAIL_LAST = PAD_BITS + TRAIL_ZERO_BITS;
   localparam int unsigned TAIL_W    = $clog2(TAIL_LAST + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV, S_GAM, S_EXEC
   } state_type;

   state_type state_ff;

   // configuration
   logic [6:0]  brightness_ff;
   logic [15:0] period_ff;
   logic [15:0] zero_high_ff;
   logic [15:0] one_high_ff;

   // store: memory plus valid bits; an invalid entry reads as fill_ff
   logic [23:0]          mem [LED_COUNT];
   logic [LED_COUNT-1:0] valid_ff;
   logic [23:0]          fill_ff;
   logic [23:0]          rd_data_ff;
   logic                 ent_valid_ff;
   logic                 in_range_ff;

   // line state
   logic [15:0]       count_ff;
   logic [4:0]        bit_in_led_ff;
   logic [PTR_W-1:0]  led_ptr_ff;
   logic [TAIL_W-1:0] tail_ff;
   logic [23:0]       shift_word_ff;

   logic [15:0]       count_in;
   logic [4:0]        bit_in_led_in;
   logic [PTR_W-1:0]  led_ptr_in;
   logic [TAIL_W-1:0] tail_in;

   // encode datapath, channel 2 red, 1 green, 0 blue
   logic [14:0] prod_ff [3];
   logic [7:0]  quot_ff [3];
   logic [27:0] recip   [3];

   req_type item_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   logic             accept;
   logic             in_data;
   logic             reload;
   logic             req_in_range;
   logic [IDX_W-1:0] rd_addr;
   logic [23:0]      entry_color;
   logic [4:0]       bit_sel;
   logic [15:0]      width;
   logic             out_free;
   logic             item_in_range;
   rsp_type          result;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign in_data      = (led_ptr_ff < PTR_W'(LED_COUNT));
   assign reload       = (req_data.func == FUNC_TICK) && in_data && (count_ff == 16'd0);
   assign req_in_range = ({1'b0, req_data.led_index} < 9'(LED_COUNT));
   assign rd_addr      = reload ? led_ptr_ff[IDX_W-1:0] : req_data.led_index[IDX_W-1:0];
   assign entry_color  = ent_valid_ff ? rd_data_ff : fill_ff;
   assign item_in_range = ({1'b0, item_ff.led_index} < 9'(LED_COUNT));

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (state_ff == S_EXEC && out_free && item_ff.func == FUNC_WRITE && item_in_range) begin
         mem[item_ff.led_index[IDX_W-1:0]] <= item_ff.new_color;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         recip[c] = 28'(prod_ff[c]) * 28'(DIV100_MUL);
      end
   end

   // line width and next counters for an executing tick
   always_comb begin
      bit_sel = 5'(LED_BITS - 1) - bit_in_led_ff;
      if (in_data) begin
         width = shift_word_ff[bit_sel] ? one_high_ff : zero_high_ff;
      end else if (tail_ff < TAIL_W'(TRAIL_ZERO_BITS)) begin
         width = zero_high_ff;
      end else begin
         width = 16'd0;
      end

      count_in      = count_ff + 16'd1;
      bit_in_led_in = bit_in_led_ff;
      led_ptr_in    = led_ptr_ff;
      tail_in       = tail_ff;
      if (count_ff >= period_ff) begin
         count_in = 16'd0;
         if (in_data) begin
            if (bit_in_led_ff == 5'(LED_BITS - 1)) begin
               bit_in_led_in = 5'd0;
               led_ptr_in    = led_ptr_ff + PTR_W'(1);
            end else begin
               bit_in_led_in = bit_in_led_ff + 5'd1;
            end
         end else if (tail_ff == TAIL_W'(TAIL_LAST)) begin
            tail_in    = '0;
            led_ptr_in = '0;
         end else begin
            tail_in = tail_ff + TAIL_W'(1);
         end
      end
   end

   always_comb begin
      result = '0;
      unique case (item_ff.func)
         FUNC_TICK: begin
            result.line_level  = (count_ff < width);
            result.frame_start = (led_ptr_ff == '0) && (bit_in_led_ff == 5'd0) &&
                                 (count_ff == 16'd0);
         end
         FUNC_READ: begin
            result.read_color = in_range_ff ? entry_color : 24'd0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         brightness_ff <= 7'd100;
         period_ff     <= 16'd104;
         zero_high_ff  <= 16'd20;
         one_high_ff   <= 16'd83;
         valid_ff      <= '0;
         fill_ff       <= 24'd0;
         count_ff      <= 16'd0;
         bit_in_led_ff <= 5'd0;
         led_ptr_ff    <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BRIGHTNESS: brightness_ff <= (csr_data[6:0] > 7'(BRIGHT_MAX)) ?
                                                7'(BRIGHT_MAX) : csr_data[6:0];
               CSR_BIT_PERIOD: period_ff    <= csr_data;
               CSR_ZERO_HIGH:  zero_high_ff <= csr_data;
               CSR_ONE_HIGH:   one_high_ff  <= csr_data;
               default:        period_ff    <= period_ff;
            endcase
         end

         if (state_ff == S_EXEC && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  item_ff      <= req_data;
                  in_range_ff  <= req_in_range;
                  ent_valid_ff <= valid_ff[rd_addr];
                  state_ff     <= reload ? S_MUL : S_EXEC;
               end
            end
            S_MUL: begin
               for (int c = 0; c < 3; c++) begin
                  prod_ff[c] <= 15'(entry_color[8*c +: 8]) * 15'(brightness_ff);
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  quot_ff[c] <= recip[c][DIV100_SHIFT +: 8];
               end
               state_ff <= S_GAM;
            end
            S_GAM: begin
               // grb order on the line
               shift_word_ff <= {GAMMA_ROM[quot_ff[1]], GAMMA_ROM[quot_ff[2]],
                                 GAMMA_ROM[quot_ff[0]]};
               state_ff      <= S_EXEC;
            end
            S_EXEC: begin
               if (out_free) begin
                  rsp_ff       <= result;
                  state_ff     <= S_IDLE;
                  unique case (item_ff.func)
                     FUNC_TICK: begin
                        count_ff      <= count_in;
                        bit_in_led_ff <= bit_in_led_in;
                        led_ptr_ff    <= led_ptr_in;
                        tail_ff       <= tail_in;
                     end
                     FUNC_WRITE: begin
                        if (item_in_range) begin
                           valid_ff[item_ff.led_index[IDX_W-1:0]] <= 1'b1;
                        end
                     end
                     FUNC_SET_ALL: begin
                        valid_ff <= '0;
                        fill_ff  <= item_ff.new_color;
                     end
                     FUNC_ALL_OFF: begin
                        valid_ff <= '0;
                        fill_ff  <= 24'd0;
                     end
                     default: begin
                        fill_ff <= fill_ff;
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
